>>> design/obtlf_pkg.sv
package obtlf_pkg;

    // Book depth and fixed field widths.
    localparam int LEVELS_DEF = 5;
    localparam int PW         = 24;
    localparam int TW         = 48;
    localparam int VOL_W      = 27;
    localparam int IMB_W      = 16;
    localparam int VWAP_W     = 32;

    localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};
    localparam logic [IMB_W-1:0] IMB_MAX = 16'h7FFF;

    // Event action codes.
    localparam logic [1:0] ACT_BID   = 2'd0;
    localparam logic [1:0] ACT_OFFER = 2'd1;
    localparam logic [1:0] ACT_TRADE = 2'd2;

    // One book slot: a bid pair and an offer pair.
    typedef struct packed {
        logic [PW-1:0] bp;
        logic [PW-1:0] bs;
        logic [PW-1:0] op;
        logic [PW-1:0] os;
    } t_slot;

    // Operation applied by every cell of the chain.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_EVENT,
        CELL_CLEAN,
        CELL_SORT,
        CELL_ROT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     phase;
    } t_cell_ctl;

endpackage

>>> design/obtlf_cell.sv
module obtlf_cell
    import obtlf_pkg::*;
#(
    parameter int IDX  = 0,
    parameter bit LAST = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cell_ctl       i_ctl,
    input  logic [1:0]      i_action,
    input  logic [2:0]      i_level,
    input  logic [PW-1:0]   i_price,
    input  logic [PW-1:0]   i_qty,
    input  logic            i_match,
    output logic            o_match,
    input  t_slot           i_left,
    input  t_slot           i_right,
    output t_slot           o_slot
);

    localparam bit ODD = 1'(IDX % 2);

    t_slot r_slot;
    t_slot n_slot;
    logic  w_bid_hit;
    logic  w_off_hit;
    logic  w_is_left;
    logic  w_is_right;
    logic  w_swap_b;
    logic  w_swap_o;

    assign o_slot    = r_slot;
    assign w_bid_hit = (r_slot.bp == i_price);
    assign w_off_hit = (r_slot.op == i_price);
    // A trade stops at the first slot, toward higher indexes, with a matching price.
    assign o_match   = i_match | w_bid_hit | w_off_hit;

    // Odd-even transposition: this cell pairs with its right or left neighbor.
    assign w_is_left  = !LAST && (ODD == i_ctl.phase);
    assign w_is_right = (IDX != 0) && (ODD != i_ctl.phase);

    always_comb begin
        w_swap_b = 1'b0;
        w_swap_o = 1'b0;
        if (w_is_left) begin
            w_swap_b = (i_right.bs != '0) && ((r_slot.bs == '0) || (r_slot.bp < i_right.bp));
            w_swap_o = (i_right.os != '0) && ((r_slot.os == '0) || (r_slot.op > i_right.op));
        end else if (w_is_right) begin
            w_swap_b = (r_slot.bs != '0) && ((i_left.bs == '0) || (i_left.bp < r_slot.bp));
            w_swap_o = (r_slot.os != '0) && ((i_left.os == '0) || (i_left.op > r_slot.op));
        end
    end

    // Next slot contents for each chain operation.
    always_comb begin
        n_slot = r_slot;
        case (i_ctl.op)
            CELL_EVENT: begin
                if (i_action == ACT_TRADE) begin
                    if (!i_match && w_bid_hit) begin
                        n_slot.bs = (r_slot.bs > i_qty) ? r_slot.bs - i_qty : '0;
                    end else if (!i_match && w_off_hit) begin
                        n_slot.os = (r_slot.os > i_qty) ? r_slot.os - i_qty : '0;
                    end
                end else if ({2'b00, i_level} == 5'(IDX + 1)) begin
                    if (i_action == ACT_BID) begin
                        n_slot.bp = i_price;
                        n_slot.bs = i_qty;
                    end else if (i_action == ACT_OFFER) begin
                        n_slot.op = i_price;
                        n_slot.os = i_qty;
                    end
                end
            end
            CELL_CLEAN: begin
                if (r_slot.bp == '0 || r_slot.bs == '0) begin
                    n_slot.bp = '0;
                    n_slot.bs = '0;
                end
                if (r_slot.op == '0 || r_slot.os == '0) begin
                    n_slot.op = '0;
                    n_slot.os = '0;
                end
            end
            CELL_SORT: begin
                if (w_swap_b) begin
                    n_slot.bp = w_is_left ? i_right.bp : i_left.bp;
                    n_slot.bs = w_is_left ? i_right.bs : i_left.bs;
                end
                if (w_swap_o) begin
                    n_slot.op = w_is_left ? i_right.op : i_left.op;
                    n_slot.os = w_is_left ? i_right.os : i_left.os;
                end
            end
            CELL_ROT: begin
                n_slot = i_right;
            end
            default: begin
                n_slot = r_slot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else begin
            r_slot <= n_slot;
        end
    end

endmodule

>>> design/obtlf_div.sv
module obtlf_div
    import obtlf_pkg::*;
#(
    parameter int NW = 64,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);

    localparam int CW = $clog2(NW);

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_quot;
    logic [CW-1:0] r_cnt;
    logic          r_run;
    logic          r_done;
    logic [DW:0]   w_trial;
    logic          w_fit;

    assign o_done  = r_done;
    assign o_quot  = r_quot;
    assign w_trial = {r_rem, r_quot[NW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    // Restoring division, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_den;
                r_quot <= i_num;
            end else if (r_run) begin
                r_rem  <= w_fit ? DW'(w_trial - {1'b0, r_den}) : w_trial[DW-1:0];
                r_quot <= {r_quot[NW-2:0], w_fit};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> design/order_book_top_levels_features_unit.sv
// Channel  | Handshake          | Ports
// ---------+--------------------+------------------------------------------------
// event    | start & !busy      | i_action i_level i_price i_quantity i_timestamp
//          |                    | i_end_of_group
// features | o_valid (1 cycle)  | o_time_since_trade ... o_offer_rising
//
// An event that does not close a group leaves busy low; the next beat may follow at once.
// A closing event keeps busy high through a clean pass, LEVELS sort phases in the cell
// chain, a rotation that accumulates size sums and price-size products for both sides,
// then three divisions on the shared bit-serial divider.
// The feature beat is shown with o_valid in the cycle busy falls again.
// Reset (i_rst_n low, synchronous) clears the book, best prices and times.
// The receiver cannot stall; every feature beat is taken as shown.
module order_book_top_levels_features_unit
    import obtlf_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_action,
    input  logic [2:0]              i_level,
    input  logic [PW-1:0]           i_price,
    input  logic [PW-1:0]           i_quantity,
    input  logic [TW-1:0]           i_timestamp,
    input  logic                    i_end_of_group,
    output logic                    o_valid,
    output logic [TW-1:0]           o_time_since_trade,
    output logic [TW-1:0]           o_time_since_update,
    output logic [PW-1:0]           o_best_bid_price,
    output logic [PW-1:0]           o_best_offer_price,
    output logic [VOL_W-1:0]        o_bid_volume,
    output logic [VOL_W-1:0]        o_offer_volume,
    output logic signed [IMB_W-1:0] o_imbalance,
    output logic [VWAP_W-1:0]       o_vwap_bid,
    output logic [VWAP_W-1:0]       o_vwap_offer,
    output logic                    o_bid_rising,
    output logic                    o_offer_rising
);

    localparam int LW = $clog2(LEVELS);
    localparam int SW = PW + LW;
    localparam int WW = 2 * PW + LW;
    localparam int NW = WW + 9;
    localparam int DW = (SW > VOL_W + 2) ? SW : VOL_W + 2;
    localparam int XW = (SW > VOL_W) ? SW : VOL_W;
    localparam int CW = $clog2(LEVELS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAN,
        S_SORT,
        S_ACC,
        S_DIVB,
        S_DIVO,
        S_DIVI
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_cnt;
    logic             r_div_run;
    logic [TW-1:0]    r_cur;
    logic [TW-1:0]    r_prev;
    logic [TW-1:0]    r_trade;
    logic [PW-1:0]    r_best_bid;
    logic [PW-1:0]    r_prior_bid;
    logic [PW-1:0]    r_best_off;
    logic [PW-1:0]    r_prior_off;
    logic [2*PW-1:0]  r_pb;
    logic [2*PW-1:0]  r_po;
    logic [WW-1:0]    r_wb;
    logic [WW-1:0]    r_wo;
    logic [SW-1:0]    r_sb;
    logic [SW-1:0]    r_so;
    logic [VWAP_W-1:0] r_vb;

    logic             w_accept;
    t_cell_ctl        w_ctl;
    t_slot            w_slot [LEVELS];
    logic             w_match [LEVELS+1];
    logic [XW-1:0]    w_sbx;
    logic [XW-1:0]    w_sox;
    logic [VOL_W-1:0] w_bvol;
    logic [VOL_W-1:0] w_ovol;
    logic [VOL_W:0]   w_den;
    logic             w_neg;
    logic [VOL_W-1:0] w_mag;
    logic             w_div_start;
    logic [NW-1:0]    w_num;
    logic [DW-1:0]    w_dvs;
    logic             w_div_done;
    logic [NW-1:0]    w_quot;
    logic [IMB_W-1:0] w_imb;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Operation broadcast to the cell chain.
    always_comb begin
        w_ctl.op    = CELL_HOLD;
        w_ctl.phase = r_cnt[0];
        case (r_state)
            S_IDLE:  w_ctl.op = w_accept ? CELL_EVENT : CELL_HOLD;
            S_CLEAN: w_ctl.op = CELL_CLEAN;
            S_SORT:  w_ctl.op = CELL_SORT;
            S_ACC:   w_ctl.op = (r_cnt < CW'(LEVELS)) ? CELL_ROT : CELL_HOLD;
            default: w_ctl.op = CELL_HOLD;
        endcase
    end

    // Chain of book slots; slot 0 holds the top of book.
    assign w_match[0] = 1'b0;
    for (genvar g = 0; g < LEVELS; g++) begin : g_cell
        obtlf_cell #(
            .IDX  (g),
            .LAST (g == LEVELS - 1)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_action (i_action),
            .i_level  (i_level),
            .i_price  (i_price),
            .i_qty    (i_quantity),
            .i_match  (w_match[g]),
            .o_match  (w_match[g+1]),
            .i_left   (w_slot[(g == 0) ? 0 : g - 1]),
            .i_right  (w_slot[(g == LEVELS - 1) ? 0 : g + 1]),
            .o_slot   (w_slot[g])
        );
    end

    // Saturated volumes and the imbalance operands.
    assign w_sbx  = XW'(r_sb);
    assign w_sox  = XW'(r_so);
    assign w_bvol = (w_sbx > XW'(VOL_MAX)) ? VOL_MAX : w_sbx[VOL_W-1:0];
    assign w_ovol = (w_sox > XW'(VOL_MAX)) ? VOL_MAX : w_sox[VOL_W-1:0];
    assign w_den  = {1'b0, w_bvol} + {1'b0, w_ovol};
    assign w_neg  = (w_ovol > w_bvol);
    assign w_mag  = w_neg ? w_ovol - w_bvol : w_bvol - w_ovol;

    // Divider operands for the division in progress.
    always_comb begin
        case (r_state)
            S_DIVB: begin
                w_num = NW'({r_wb, 8'd0}) + NW'(r_sb >> 1);
                w_dvs = DW'(r_sb);
            end
            S_DIVO: begin
                w_num = NW'({r_wo, 8'd0}) + NW'(r_so >> 1);
                w_dvs = DW'(r_so);
            end
            default: begin
                w_num = NW'({w_mag, 16'd0}) + NW'(w_den);
                w_dvs = DW'({w_den, 1'b0});
            end
        endcase
    end

    assign w_div_start = !r_div_run &&
                         (r_state == S_DIVB || r_state == S_DIVO || r_state == S_DIVI);

    obtlf_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_dvs),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Rounded quotient mapped to Q1.15 with positive saturation.
    always_comb begin
        if (w_den == '0) begin
            w_imb = '0;
        end else if (w_neg) begin
            w_imb = IMB_W'(0) - w_quot[IMB_W-1:0];
        end else if (w_quot > NW'(IMB_MAX)) begin
            w_imb = IMB_MAX;
        end else begin
            w_imb = w_quot[IMB_W-1:0];
        end
    end

    // Sequencer, times, best prices, sums and the feature beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_div_run   <= 1'b0;
            r_cur       <= '0;
            r_prev      <= '0;
            r_trade     <= '0;
            r_best_bid  <= '0;
            r_prior_bid <= '0;
            r_best_off  <= '0;
            r_prior_off <= '0;
            o_valid     <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_timestamp != r_cur) begin
                            r_prev <= r_cur;
                            r_cur  <= i_timestamp;
                        end
                        if (i_action == ACT_TRADE) begin
                            r_trade <= i_timestamp;
                        end
                        if (i_end_of_group) begin
                            r_state <= S_CLEAN;
                        end
                    end
                end
                S_CLEAN: begin
                    r_cnt   <= '0;
                    r_state <= S_SORT;
                end
                S_SORT: begin
                    if (r_cnt == CW'(LEVELS - 1)) begin
                        r_cnt   <= '0;
                        r_pb    <= '0;
                        r_po    <= '0;
                        r_wb    <= '0;
                        r_wo    <= '0;
                        r_sb    <= '0;
                        r_so    <= '0;
                        r_state <= S_ACC;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_ACC: begin
                    if (r_cnt == '0) begin
                        if (w_slot[0].bp != '0 && w_slot[0].bp != r_best_bid) begin
                            r_prior_bid <= r_best_bid;
                            r_best_bid  <= w_slot[0].bp;
                        end
                        if (w_slot[0].op != '0 && w_slot[0].op != r_best_off) begin
                            r_prior_off <= r_best_off;
                            r_best_off  <= w_slot[0].op;
                        end
                    end
                    r_wb <= r_wb + WW'(r_pb);
                    r_wo <= r_wo + WW'(r_po);
                    if (r_cnt < CW'(LEVELS)) begin
                        r_pb  <= w_slot[0].bp * w_slot[0].bs;
                        r_po  <= w_slot[0].op * w_slot[0].os;
                        r_sb  <= r_sb + SW'(w_slot[0].bs);
                        r_so  <= r_so + SW'(w_slot[0].os);
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_state <= S_DIVB;
                    end
                end
                S_DIVB: begin
                    if (!r_div_run) begin
                        r_div_run <= 1'b1;
                    end else if (w_div_done) begin
                        r_div_run <= 1'b0;
                        r_vb      <= (r_sb == '0) ? '0 : w_quot[VWAP_W-1:0];
                        r_state   <= S_DIVO;
                    end
                end
                S_DIVO: begin
                    if (!r_div_run) begin
                        r_div_run <= 1'b1;
                    end else if (w_div_done) begin
                        r_div_run    <= 1'b0;
                        o_vwap_offer <= (r_so == '0) ? '0 : w_quot[VWAP_W-1:0];
                        r_state      <= S_DIVI;
                    end
                end
                S_DIVI: begin
                    if (!r_div_run) begin
                        r_div_run <= 1'b1;
                    end else if (w_div_done) begin
                        r_div_run           <= 1'b0;
                        o_imbalance         <= w_imb;
                        o_vwap_bid          <= r_vb;
                        o_bid_volume        <= w_bvol;
                        o_offer_volume      <= w_ovol;
                        o_time_since_trade  <= r_cur - r_trade;
                        o_time_since_update <= r_cur - r_prev;
                        o_best_bid_price    <= r_best_bid;
                        o_best_offer_price  <= r_best_off;
                        o_bid_rising        <= (r_best_bid > r_prior_bid);
                        o_offer_rising      <= (r_best_off > r_prior_off);
                        o_valid             <= 1'b1;
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/obtlf_chk.sv
module obtlf_chk
    import obtlf_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_end_of_group,
    input logic o_valid
);

    // A closing event makes the block busy in the next cycle.
    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_end_of_group |=> busy)
        else $error("closing beat did not raise busy");

    // A feature beat ends a busy stretch.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy))
        else $error("feature beat without a busy stretch");

    // The strobe lasts one cycle.
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("feature strobe held");

    // A non-closing event leaves the block ready.
    a_open_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_end_of_group |=> !busy && !o_valid)
        else $error("open-group beat disturbed the block");

endmodule

bind order_book_top_levels_features_unit obtlf_chk u_obtlf_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_end_of_group (i_end_of_group),
    .o_valid        (o_valid)
);

>>> tb/order_book_features_checker.sv
module order_book_features_checker
    import obtlf_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    input  logic                    busy,
    input  logic [1:0]              i_action,
    input  logic [2:0]              i_level,
    input  logic [PW-1:0]           i_price,
    input  logic [PW-1:0]           i_quantity,
    input  logic [TW-1:0]           i_timestamp,
    input  logic                    i_end_of_group,
    input  logic                    o_valid,
    input  logic [TW-1:0]           o_time_since_trade,
    input  logic [TW-1:0]           o_time_since_update,
    input  logic [PW-1:0]           o_best_bid_price,
    input  logic [PW-1:0]           o_best_offer_price,
    input  logic [VOL_W-1:0]        o_bid_volume,
    input  logic [VOL_W-1:0]        o_offer_volume,
    input  logic signed [IMB_W-1:0] o_imbalance,
    input  logic [VWAP_W-1:0]       o_vwap_bid,
    input  logic [VWAP_W-1:0]       o_vwap_offer,
    input  logic                    o_bid_rising,
    input  logic                    o_offer_rising,
    output int                      failures,
    output int                      features_pending,
    output int                      features_seen
);

    localparam int N = LEVELS_DEF;

    typedef logic [N-1:0][PW-1:0] t_col;

    typedef struct packed {
        t_col px;
        t_col sz;
    } t_side;

    typedef struct packed {
        logic [TW-1:0]     since_trade;
        logic [TW-1:0]     since_update;
        logic [PW-1:0]     bid_top;
        logic [PW-1:0]     offer_top;
        logic [VOL_W-1:0]  bid_vol;
        logic [VOL_W-1:0]  offer_vol;
        logic [IMB_W-1:0]  imb;
        logic [VWAP_W-1:0] bid_avg_px;
        logic [VWAP_W-1:0] offer_avg_px;
        logic              bid_up;
        logic              offer_up;
    } t_features;

    // Shadow copy of the book and the timing state.
    t_side         bids, offers;
    logic [PW-1:0] bid_top, prior_bid, offer_top, prior_offer;
    logic [TW-1:0] now_time, prev_time, trade_ts;
    t_features     expected_features[$];

    // Drop empty slots, insertion-sort the rest (stable), zero-fill the tail.
    function automatic t_side compact_sort(t_side s, bit descending);
        t_side r;
        int    n;
        int    j;
        r = '0;
        n = 0;
        for (int i = 0; i < N; i++) begin
            if (s.px[i] != 0 && s.sz[i] != 0) begin
                j = n;
                while (j > 0 && (descending ? r.px[j-1] < s.px[i] : r.px[j-1] > s.px[i])) begin
                    r.px[j] = r.px[j-1];
                    r.sz[j] = r.sz[j-1];
                    j--;
                end
                r.px[j] = s.px[i];
                r.sz[j] = s.sz[i];
                n++;
            end
        end
        return r;
    endfunction

    // Size-weighted price with 8 fraction bits, rounded half up.
    function automatic logic [63:0] weighted_price(t_side s);
        logic [63:0] w;
        logic [63:0] total;
        w = 0;
        total = 0;
        for (int i = 0; i < N; i++) begin
            w += 64'(s.px[i]) * 64'(s.sz[i]);
            total += 64'(s.sz[i]);
        end
        if (total == 0) return 0;
        return ((w << 8) + (total >> 1)) / total;
    endfunction

    function automatic logic [VOL_W-1:0] side_volume(t_side s);
        logic [63:0] total;
        total = 0;
        for (int i = 0; i < N; i++) total += 64'(s.sz[i]);
        return (total > 64'(VOL_MAX)) ? VOL_MAX : total[VOL_W-1:0];
    endfunction

    // Q1.15 imbalance, round to nearest with ties away from zero.
    function automatic logic [IMB_W-1:0] book_imbalance(logic [63:0] b, logic [63:0] o);
        logic [63:0] den;
        logic [63:0] mag;
        logic [63:0] q;
        den = b + o;
        if (den == 0) return 0;
        mag = ((o > b) ? o - b : b - o) << 15;
        q = (2 * mag + den) / (2 * den);
        if (o > b) return 16'((17'h10000 - q[16:0]));
        return (q > 32767) ? IMB_MAX : q[IMB_W-1:0];
    endfunction

    // Apply one accepted event to the shadow book.
    task automatic apply_event(logic [1:0] act, logic [2:0] lvl, logic [PW-1:0] px,
                               logic [PW-1:0] qty, logic [TW-1:0] ts, logic eog);
        t_features f;
        bit        hit;
        if (ts != now_time) begin
            prev_time = now_time;
            now_time  = ts;
        end
        if (act == ACT_TRADE) trade_ts = ts;
        if ((act == ACT_BID || act == ACT_OFFER) && lvl >= 1 && lvl <= N) begin
            if (act == ACT_BID) begin
                bids.px[lvl-1] = px;
                bids.sz[lvl-1] = qty;
            end else begin
                offers.px[lvl-1] = px;
                offers.sz[lvl-1] = qty;
            end
        end else if (act == ACT_TRADE) begin
            hit = 0;
            for (int i = 0; i < N && !hit; i++) begin
                if (bids.px[i] == px) begin
                    bids.sz[i] = (bids.sz[i] > qty) ? bids.sz[i] - qty : '0;
                    hit = 1;
                end else if (offers.px[i] == px) begin
                    offers.sz[i] = (offers.sz[i] > qty) ? offers.sz[i] - qty : '0;
                    hit = 1;
                end
            end
        end
        if (!eog) return;

        bids   = compact_sort(bids, 1'b1);
        offers = compact_sort(offers, 1'b0);
        if (bids.px[0] != 0 && bids.px[0] != bid_top) begin
            prior_bid = bid_top;
            bid_top   = bids.px[0];
        end
        if (offers.px[0] != 0 && offers.px[0] != offer_top) begin
            prior_offer = offer_top;
            offer_top   = offers.px[0];
        end
        f.since_trade  = now_time - trade_ts;
        f.since_update = now_time - prev_time;
        f.bid_top      = bid_top;
        f.offer_top    = offer_top;
        f.bid_vol      = side_volume(bids);
        f.offer_vol    = side_volume(offers);
        f.imb          = book_imbalance(64'(f.bid_vol), 64'(f.offer_vol));
        f.bid_avg_px   = VWAP_W'(weighted_price(bids));
        f.offer_avg_px = VWAP_W'(weighted_price(offers));
        f.bid_up       = bid_top > prior_bid;
        f.offer_up     = offer_top > prior_offer;
        expected_features = {expected_features, f};
    endtask

    task automatic report(string field, logic [63:0] exp_v, logic [63:0] act_v);
        $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, field, exp_v, act_v);
        failures++;
    endtask

    // Compare each feature beat against the oldest prediction, then absorb new events.
    always @(posedge i_clk) begin
        t_features e;
        if (!i_rst_n) begin
            bids = '0;
            offers = '0;
            bid_top = '0;
            prior_bid = '0;
            offer_top = '0;
            prior_offer = '0;
            now_time = '0;
            prev_time = '0;
            trade_ts = '0;
            expected_features.delete();
            failures = 0;
            features_seen = 0;
        end else begin
            if (o_valid) begin
                features_seen++;
                if (expected_features.size() == 0) begin
                    $display("%0t: unexpected feature beat", $time);
                    failures++;
                end else begin
                    e = expected_features.pop_front();
                    if (o_time_since_trade !== e.since_trade)
                        report("time_since_trade", e.since_trade, o_time_since_trade);
                    if (o_time_since_update !== e.since_update)
                        report("time_since_update", e.since_update, o_time_since_update);
                    if (o_best_bid_price !== e.bid_top)
                        report("best_bid_price", e.bid_top, o_best_bid_price);
                    if (o_best_offer_price !== e.offer_top)
                        report("best_offer_price", e.offer_top, o_best_offer_price);
                    if (o_bid_volume !== e.bid_vol)
                        report("bid_volume", e.bid_vol, o_bid_volume);
                    if (o_offer_volume !== e.offer_vol)
                        report("offer_volume", e.offer_vol, o_offer_volume);
                    if (o_imbalance !== e.imb)
                        report("imbalance", e.imb, o_imbalance);
                    if (o_vwap_bid !== e.bid_avg_px)
                        report("bid vwap", e.bid_avg_px, o_vwap_bid);
                    if (o_vwap_offer !== e.offer_avg_px)
                        report("offer vwap", e.offer_avg_px, o_vwap_offer);
                    if (o_bid_rising !== e.bid_up)
                        report("bid_rising", e.bid_up, o_bid_rising);
                    if (o_offer_rising !== e.offer_up)
                        report("offer_rising", e.offer_up, o_offer_rising);
                end
            end
            if (start && !busy)
                apply_event(i_action, i_level, i_price, i_quantity, i_timestamp,
                            i_end_of_group);
        end
        features_pending = expected_features.size();
    end

endmodule

>>> tb/order_book_top_levels_features_unit_test.sv
module order_book_top_levels_features_unit_test;
    import obtlf_pkg::*;

    localparam logic [1:0] ACT_SPARE = 2'd3;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [1:0]              i_action = '0;
    logic [2:0]              i_level = '0;
    logic [PW-1:0]           i_price = '0;
    logic [PW-1:0]           i_quantity = '0;
    logic [TW-1:0]           i_timestamp = '0;
    logic                    i_end_of_group = 1'b0;
    logic                    o_valid;
    logic [TW-1:0]           o_time_since_trade, o_time_since_update;
    logic [PW-1:0]           o_best_bid_price, o_best_offer_price;
    logic [VOL_W-1:0]        o_bid_volume, o_offer_volume;
    logic signed [IMB_W-1:0] o_imbalance;
    logic [VWAP_W-1:0]       o_vwap_bid, o_vwap_offer;
    logic                    o_bid_rising, o_offer_rising;
    int                      failures, features_pending, features_seen;
    int                      sender_idle_pct;
    int                      events_sent;
    logic [TW-1:0]           clock_ticks;
    logic [PW-1:0]           center_px;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    order_book_top_levels_features_unit dut (.*);

    order_book_features_checker checker_inst (.*);

    // Drive one event beat and hold it until the block takes it.
    task automatic send_event(logic [1:0] act, logic [2:0] lvl, logic [PW-1:0] px,
                              logic [PW-1:0] qty, logic [TW-1:0] ts, logic eog);
        int gap;
        gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start          <= 1'b1;
        i_action       <= act;
        i_level        <= lvl;
        i_price        <= px;
        i_quantity     <= qty;
        i_timestamp    <= ts;
        i_end_of_group <= eog;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        events_sent++;
    endtask

    // Hold off new beats until every predicted feature beat has been seen.
    task automatic drain;
        start <= 1'b0;
        while (features_pending != 0) @(negedge i_clk);
    endtask

    // One group of random events around a drifting center price.
    task automatic random_group;
        int          len;
        int          r;
        logic [1:0]  act;
        logic [2:0]  lvl;
        logic [PW-1:0] px, qty;
        r = $urandom_range(99);
        if (r < 3) clock_ticks = clock_ticks - TW'($urandom_range(1, 500));
        else if (r < 6) clock_ticks = TW'({$urandom, $urandom});
        else clock_ticks = clock_ticks + TW'($urandom_range(0, 300));
        if ($urandom_range(9) == 0) center_px = PW'($urandom);
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(99);
            act = (r < 40) ? ACT_BID : (r < 80) ? ACT_OFFER : (r < 95) ? ACT_TRADE : ACT_SPARE;
            lvl = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 5));
            px  = ($urandom_range(19) == 0) ? PW'($urandom) :
                  (($urandom_range(29) == 0) ? '0 :
                   center_px + PW'($urandom_range(0, 12)) - PW'(6));
            qty = ($urandom_range(9) == 0) ? PW'($urandom) :
                  (($urandom_range(14) == 0) ? '0 : PW'($urandom_range(1, 2000)));
            send_event(act, lvl, px, qty, clock_ticks, k == len - 1);
        end
    endtask

    initial begin
        events_sent = 0;
        clock_ticks = 100;
        center_px   = 24'd5000;
        sender_idle_pct = 29;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: full-scale book, trade cases, bad levels, spare action, time wrap.
        for (int l = 1; l <= 5; l++) begin
            send_event(ACT_BID, 3'(l), {PW{1'b1}} - PW'(l), {PW{1'b1}}, 48'd10, 1'b0);
            send_event(ACT_OFFER, 3'(l), PW'(l), {PW{1'b1}}, 48'd10, l == 5);
        end
        send_event(ACT_TRADE, 3'd0, {PW{1'b1}} - PW'(1), {PW{1'b1}}, 48'd20, 1'b0);
        send_event(ACT_TRADE, 3'd7, PW'(3), 24'd100, 48'd20, 1'b0);
        send_event(ACT_TRADE, 3'd1, 24'd777, 24'd5, 48'd20, 1'b1);
        send_event(ACT_TRADE, 3'd1, '0, 24'd5, 48'd30, 1'b1);
        send_event(ACT_BID, 3'd0, 24'd99, 24'd99, 48'd40, 1'b0);
        send_event(ACT_OFFER, 3'd6, 24'd99, 24'd99, 48'd40, 1'b0);
        send_event(ACT_BID, 3'd7, 24'd99, 24'd99, 48'd40, 1'b1);
        send_event(ACT_SPARE, 3'd2, {PW{1'b1}}, {PW{1'b1}}, {TW{1'b1}}, 1'b1);
        send_event(ACT_BID, 3'd3, '0, 24'd50, 48'd5, 1'b0);
        send_event(ACT_OFFER, 3'd4, 24'd60, '0, 48'd5, 1'b1);

        // Random events in three idling phases, draining between them.
        for (int ph = 0; ph < 3; ph++) begin
            drain();
            sender_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 74 : 0;
            while (events_sent < 20 + (ph + 1) * 610) random_group();
        end

        drain();
        repeat (400) @(posedge i_clk);
        $display("Sent %0d events; checked %0d feature beats over three idling phases.",
                 events_sent, features_seen);
        if (failures == 0 && features_pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timeout with %0d feature beats outstanding.", features_pending);
        $display("Test completed with failures");
        $finish;
    end

endmodule
